FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Included by the top level; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/puf_pkg.sv
// Shared types and constants of the persistent union-find.
// No dependencies.
package puf_pkg;
   localparam logic [1:0] REQ_UNITE    = 2'd0;
   localparam logic [1:0] REQ_CONN     = 2'd1;
   localparam logic [1:0] REQ_EARLIEST = 2'd2;
   localparam int         REQ_BITS     = 2;
   localparam int         FIELD_NODE_BITS = 10;
   localparam int         FIELD_TIME_BITS = 16;

   // find unit control
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } find_ctl_type;
endpackage

FILE: rtl/core/persistent_union_find.sv
// Persistent union-find with union by size: top level and sequencer.
// Depends on puf_pkg, puf_find and assert_macros.svh.
//
// Usage: one request item enters on req_ (tdata: req_type, node_a,
// node_b, query_time) and gives exactly one response item on rsp_
// (tdata: merged, connected, found, earliest_time, rejected).
// One request is worked at a time; req_tready is low meanwhile.
// Every find goes through a single shared find unit that checks one
// parent link per memory read (states F_READ then F_CHECK); a node
// lies at depth d with d at most log2(NODES). An earliest query runs
// up to TIME_BITS+1 binary search steps, each with a find of node_a
// and of node_b. Out-of-range nodes or an unknown kind go from
// acceptance straight to S_RESP, which then raises rsp_tvalid. The
// response is held in an output register until rsp_tready; the next
// request is taken only after it is delivered.
// After reset a clearing pass over all NODES entries (1024 by default)
// makes every node its own root with a set size of one and a zero stamp;
// req_tready stays low until it ends.
module persistent_union_find #(
   parameter int NODES     = 1024,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] req_type, [11:2] node_a, [21:12] node_b, [37:22] query_time
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] merged, [1] connected, [2] found, [18:3] earliest_time, [19] rejected
   output logic [23:0] rsp_tdata
);
`include "assert_macros.svh"
   localparam int NB = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CB = TIME_BITS + 1;
   localparam int SB = NB + 1;
   localparam int FB = puf_pkg::FIELD_NODE_BITS;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_FIND_A, S_WAIT_A, S_FIND_B, S_WAIT_B,
      S_SIZE, S_LINK, S_STEP, S_RESP
   } state_type;

   logic [puf_pkg::REQ_BITS-1:0]        kind;
   logic [FB-1:0]                       a_in, b_in;
   logic [puf_pkg::FIELD_TIME_BITS-1:0] qt_in;
   assign kind  = req_tdata[1:0];
   assign a_in  = req_tdata[11:2];
   assign b_in  = req_tdata[21:12];
   assign qt_in = req_tdata[37:22];

   state_type             state_ff;
   logic [1:0]            kind_ff;
   logic [NB-1:0]         a_ff, b_ff;
   logic [TIME_BITS-1:0]  when_ff;
   logic [CB-1:0]         count_ff;
   logic [CB-1:0]         lo_ff, hi_ff;
   logic [NB-1:0]         ra_ff;
   logic                  merged_ff, conn_ff, found_ff, rej_ff;
   logic [15:0]           early_ff;
   logic                  rsp_valid_ff;
   logic [NB-1:0]         clr_ff;

   logic [SB-1:0]         size_mem [NODES];
   logic [SB-1:0]         sa_rd_ff, sb_rd_ff;
   logic [NB-1:0]         size_rd_addr;
   logic                  size_wr;
   logic [NB-1:0]         size_wr_addr;
   logic [SB-1:0]         size_wr_data;

   logic                  clearing;
   logic                  f_start;
   logic [NB-1:0]         f_node;
   puf_pkg::find_ctl_type f_ctl;
   logic [NB-1:0]         f_root;
   logic                  l_wr;
   logic [NB-1:0]         l_node, l_par;
   logic [TIME_BITS-1:0]  l_stamp;
   logic [SB-1:0]         size_a, size_b;
   logic                  a_small;
   logic [CB-1:0]         mid;
   logic [TIME_BITS-1:0]  conn_when;

   assign size_a  = sa_rd_ff;
   assign size_b  = sb_rd_ff;
   assign a_small = !(size_a > size_b);
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   // query_time past the top stamp saturates to the top stamp
   assign conn_when = (64'(qt_in) > ((64'd1 << TIME_BITS) - 64'd1)) ?
                      '1 : TIME_BITS'(qt_in);

   puf_find #(.NODES(NODES), .TIME_BITS(TIME_BITS), .NB(NB)) u_find (
      .clock(clock), .reset(reset), .start(f_start), .start_node(f_node),
      .when(when_ff), .ctl(f_ctl), .root(f_root),
      .wr_en(l_wr), .wr_node(l_node), .wr_parent(l_par),
      .wr_stamp(l_stamp)
   );

   assign clearing = (state_ff == S_CLEAR);
   assign f_start = (state_ff == S_FIND_A) || (state_ff == S_FIND_B);
   assign f_node  = (state_ff == S_FIND_A) ? a_ff : b_ff;
   assign l_wr    = clearing || ((state_ff == S_LINK) && (ra_ff != f_root));
   assign l_node  = clearing ? clr_ff : (a_small ? ra_ff : f_root);
   assign l_par   = clearing ? clr_ff : (a_small ? f_root : ra_ff);
   assign l_stamp = clearing ? '0 : count_ff[TIME_BITS-1:0];
   assign size_wr      = l_wr;
   assign size_wr_addr = l_par;
   assign size_wr_data = clearing ? SB'(1) : size_a + size_b;
   assign size_rd_addr = (state_ff == S_SIZE) ? f_root : ra_ff;

   always_ff @(posedge clock) begin
      if (size_wr) size_mem[size_wr_addr] <= size_wr_data;
      sb_rd_ff <= size_mem[size_rd_addr];
      sa_rd_ff <= sb_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         when_ff      <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         ra_ff        <= '0;
         merged_ff    <= 1'b0;
         conn_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rej_ff       <= 1'b0;
         early_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (clr_ff == NB'(NODES - 1)) state_ff <= S_IDLE;
               clr_ff <= clr_ff + NB'(1);
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff   <= kind;
                  a_ff      <= NB'(a_in);
                  b_ff      <= NB'(b_in);
                  merged_ff <= 1'b0;
                  conn_ff   <= 1'b0;
                  found_ff  <= 1'b0;
                  rej_ff    <= 1'b0;
                  early_ff  <= '0;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  when_ff   <= (kind == puf_pkg::REQ_CONN) ?
                               conn_when : count_ff[TIME_BITS-1:0];
                  if ((32'(a_in) >= NODES) || (32'(b_in) >= NODES) ||
                      (kind != puf_pkg::REQ_UNITE && kind != puf_pkg::REQ_CONN &&
                       kind != puf_pkg::REQ_EARLIEST)) begin
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_DECODE;
                  end
               end
            end
            S_DECODE: begin
               priority if (kind_ff == puf_pkg::REQ_UNITE) begin
                  if (count_ff[TIME_BITS]) begin
                     rej_ff   <= 1'b1;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_FIND_A;
                  end
               end else if (kind_ff == puf_pkg::REQ_CONN) begin
                  state_ff <= S_FIND_A;
               end else begin
                  if (lo_ff < hi_ff) begin
                     when_ff  <= mid[TIME_BITS-1:0];
                     state_ff <= S_FIND_A;
                  end else begin
                     if (lo_ff < count_ff) begin
                        found_ff <= 1'b1;
                        early_ff <= 16'(lo_ff);
                     end
                     state_ff <= S_RESP;
                  end
               end
            end
            S_FIND_A: state_ff <= S_WAIT_A;
            S_WAIT_A: begin
               if (f_ctl.done) begin
                  ra_ff    <= f_root;
                  state_ff <= S_FIND_B;
               end
            end
            S_FIND_B: state_ff <= S_WAIT_B;
            S_WAIT_B: begin
               if (f_ctl.done) begin
                  priority if (kind_ff == puf_pkg::REQ_UNITE) begin
                     state_ff <= S_SIZE;
                  end else if (kind_ff == puf_pkg::REQ_CONN) begin
                     conn_ff  <= (ra_ff == f_root);
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_STEP;
                  end
               end
            end
            S_SIZE: state_ff <= S_LINK;   // read size of ra then rb
            S_LINK: begin
               merged_ff <= (ra_ff != f_root);
               count_ff  <= count_ff + CB'(1);
               state_ff  <= S_RESP;
            end
            S_STEP: begin
               if (ra_ff == f_root) hi_ff <= mid;
               else lo_ff <= mid + CB'(1);
               state_ff <= S_DECODE;
            end
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
               end else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rej_ff, early_ff, found_ff, conn_ff, merged_ff};

   `ASSERT_IMPL(a_rsp_in_resp, clock, reset, rsp_valid_ff, state_ff == S_RESP)
   `ASSERT_IMPL(a_one_flag, clock, reset, rsp_valid_ff,
                $onehot0({merged_ff, conn_ff, found_ff, rej_ff}))
   `ASSERT_NEXT(a_count_step, clock, reset, state_ff == S_LINK,
                count_ff == $past(count_ff) + CB'(1))
   `ASSERT_IMPL(a_find_idle_start, clock, reset, f_start, !f_ctl.busy)
endmodule

FILE: rtl/core/puf_find.sv
// Shared find unit: walks parent links of one node as of a time stamp,
// one link per memory read. Owns the link and stamp memories. Uses puf_pkg.
module puf_find #(
   parameter int NODES     = 1024,
   parameter int TIME_BITS = 16,
   parameter int NB        = (NODES > 1) ? $clog2(NODES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NB-1:0]        start_node,
   input  logic [TIME_BITS-1:0] when,
   output puf_pkg::find_ctl_type ctl,
   output logic [NB-1:0]        root,
   // link write port
   input  logic                 wr_en,
   input  logic [NB-1:0]        wr_node,
   input  logic [NB-1:0]        wr_parent,
   input  logic [TIME_BITS-1:0] wr_stamp
);
   typedef enum logic [1:0] {F_IDLE, F_READ, F_CHECK} fstate_type;

   logic [NB-1:0]        parent_mem [NODES];
   logic [TIME_BITS-1:0] stamp_mem  [NODES];

   fstate_type           state_ff;
   logic [NB-1:0]        node_ff;
   logic [NB-1:0]        up_ff;
   logic [TIME_BITS-1:0] st_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_mem[wr_node] <= wr_parent;
         stamp_mem[wr_node]  <= wr_stamp;
      end
      up_ff <= parent_mem[node_ff];
      st_ff <= stamp_mem[node_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         node_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: begin
               if (start) begin
                  node_ff  <= start_node;
                  state_ff <= F_READ;
               end
            end
            F_READ: begin
               state_ff <= F_CHECK;
            end
            F_CHECK: begin
               if (up_ff == node_ff || st_ff > when) begin
                  done_ff  <= 1'b1;
                  state_ff <= F_IDLE;
               end else begin
                  node_ff  <= up_ff;
                  state_ff <= F_READ;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign ctl.start = start;
   assign ctl.busy  = (state_ff != F_IDLE);
   assign ctl.done  = done_ff;
   assign root      = node_ff;
endmodule
